### rtl/prts_pkg.sv
// Shared types and constants of the priority round-robin thread scheduler.
package prts_pkg;

    localparam int THREAD_SLOTS = 8;
    localparam int EVENT_SLOTS  = 8;
    localparam int SLOT_BITS    = 3;
    localparam int EV_BITS      = 3;
    localparam int TIME_BITS    = 32;
    localparam int ID_BITS      = 32;
    localparam int PRIO_BITS    = 8;

    // item kinds
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_SCHED     = 3'd1;
    localparam logic [2:0] KIND_ADD       = 3'd2;
    localparam logic [2:0] KIND_KILL_ID   = 3'd3;
    localparam logic [2:0] KIND_KILL_SELF = 3'd4;
    localparam logic [2:0] KIND_SLEEP     = 3'd5;
    localparam logic [2:0] KIND_ADD_EV    = 3'd6;
    localparam logic [2:0] KIND_SET_BLK   = 3'd7;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_NO_FREE = 3'd2;
    localparam logic [2:0] ST_LAST    = 3'd3;
    localparam logic [2:0] ST_NO_THR  = 3'd4;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [TIME_BITS-1:0] wake;
        logic [ID_BITS-1:0]   ident;
        logic [SLOT_BITS-1:0] nxt;
        logic [SLOT_BITS-1:0] prv;
    } thr_entry_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        thr_entry_t           data;
    } thr_wr_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] due;
    } ev_entry_t;

    typedef struct packed {
        logic               en;
        logic [EV_BITS-1:0] addr;
        ev_entry_t          data;
    } ev_wr_t;

endpackage

### rtl/prts_in_if.sv
// Command channel: one scheduler command per item.
interface prts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  priority_req;
    logic [31:0] target_id;
    logic [31:0] sleep_ticks;
    logic [31:0] event_period;
    logic [2:0]  target_slot;
    logic        block_value;

    modport source (output valid, kind, priority_req, target_id, sleep_ticks,
                    event_period, target_slot, block_value, input ready);
    modport sink (input valid, kind, priority_req, target_id, sleep_ticks,
                  event_period, target_slot, block_value, output ready);
endinterface

### rtl/prts_out_if.sv
// Result channel: one result item per command.
interface prts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  running_slot;
    logic [31:0] running_id;
    logic        switch_request;
    logic [7:0]  fired_events;
    logic [31:0] new_id;

    modport source (output valid, status, running_slot, running_id,
                    switch_request, fired_events, new_id, input ready);
    modport sink (input valid, status, running_slot, running_id,
                  switch_request, fired_events, new_id, output ready);
endinterface

### rtl/prts_thr_mem.sv
// Thread table memory: one write port, one read port with registered data.
module prts_thr_mem (
    input  logic                          clk,
    input  logic [prts_pkg::SLOT_BITS-1:0] raddr,
    input  prts_pkg::thr_wr_t             wr,
    output prts_pkg::thr_entry_t          q
);
    import prts_pkg::*;

    thr_entry_t mem [THREAD_SLOTS];

    // write, then register the read entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        q <= mem[raddr];
    end
endmodule

### rtl/prts_ev_mem.sv
// Periodic event memory: one write port, one read port with registered data.
module prts_ev_mem (
    input  logic                        clk,
    input  logic [prts_pkg::EV_BITS-1:0] raddr,
    input  prts_pkg::ev_wr_t            wr,
    output prts_pkg::ev_entry_t         q
);
    import prts_pkg::*;

    ev_entry_t mem [EVENT_SLOTS];

    // write, then register the read entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        q <= mem[raddr];
    end
endmodule

### rtl/priority_round_robin_thread_scheduler.sv
// Top level: command sequencer around the thread and event memories.
// The scheduler takes one command at a time and answers each with one result item.
// Thread table and event table sit in synchronous memories; a sequencer reads,
// modifies and writes entries back, one entry at a time. Kill by id searches
// the slots one by one; a schedule walks the ring after the running slot (at
// most 8 steps); a tick checks every registered event, then walks the same ring.
// The next command is taken while the previous result still waits in the output
// register.
module priority_round_robin_thread_scheduler (
    input logic       clk,
    input logic       rst_n,
    prts_in_if.sink   cmd,
    prts_out_if.source rsp
);
    import prts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ADD_RD, S_ADD_GET, S_UNL_RD, S_UNL_GET,
        S_P1_RD, S_P1_WR, S_P2_RD, S_P2_WR, S_SLP_RD, S_SLP_WR,
        S_FIND_TEST, S_FIND_CHK, S_EV_TEST, S_EV_CHK,
        S_WALK_RD0, S_WALK_GET0, S_WALK_TEST, S_WALK_CHK, S_FIN_RD, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [THREAD_SLOTS-1:0] alive_reg, alive_next;
    logic [THREAD_SLOTS-1:0] blk_reg, blk_next;
    logic [THREAD_SLOTS-1:0] slp_reg, slp_next;
    logic [SLOT_BITS-1:0]    run_reg, run_next;
    logic [3:0]              live_reg, live_next;
    logic [15:0]             idc_reg, idc_next;
    logic [TIME_BITS-1:0]    tick_reg, tick_next;
    logic [3:0]              evc_reg, evc_next;

    // latched command
    logic [2:0]           kind_reg, kind_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [ID_BITS-1:0]   tid_reg, tid_next;
    logic [TIME_BITS-1:0] sl_reg, sl_next;
    logic [TIME_BITS-1:0] per_reg, per_next;
    logic [2:0]           tslot_reg, tslot_next;
    logic                 bval_reg, bval_next;

    // work registers
    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [8:0]           best_reg, best_next;
    logic [SLOT_BITS-1:0] pick_reg, pick_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [SLOT_BITS-1:0] anc_reg, anc_next;
    logic [SLOT_BITS-1:0] p1s_reg, p1s_next, p1v_reg, p1v_next;
    logic [SLOT_BITS-1:0] p2s_reg, p2s_next, p2v_reg, p2v_next;
    logic [2:0]           st_reg, st_next;
    logic                 sw_reg, sw_next;
    logic [7:0]           fired_reg, fired_next;
    logic [31:0]          nid_reg, nid_next;

    // output register
    logic        ov_reg, ov_next;
    logic [2:0]  o_st_reg, o_st_next;
    logic [2:0]  o_rs_reg, o_rs_next;
    logic [31:0] o_rid_reg, o_rid_next;
    logic        o_sw_reg, o_sw_next;
    logic [7:0]  o_fe_reg, o_fe_next;
    logic [31:0] o_nid_reg, o_nid_next;

    logic [SLOT_BITS-1:0] thr_raddr;
    thr_wr_t              thr_wr;
    thr_entry_t           thr_q;
    logic [EV_BITS-1:0]   ev_raddr;
    ev_wr_t               ev_wr;
    ev_entry_t            ev_q;

    logic                 free_found;
    logic [SLOT_BITS-1:0] free_idx, first_alive;

    prts_thr_mem u_thr (.clk(clk), .raddr(thr_raddr), .wr(thr_wr), .q(thr_q));
    prts_ev_mem  u_ev  (.clk(clk), .raddr(ev_raddr), .wr(ev_wr), .q(ev_q));

    // find lowest dead slot and lowest live slot
    always_comb
    begin
        free_found  = 1'b0;
        free_idx    = '0;
        first_alive = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (!alive_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_BITS'(i);
            end
            else
            begin
                first_alive = SLOT_BITS'(i);
            end
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = ov_reg;
    assign rsp.status         = o_st_reg;
    assign rsp.running_slot   = o_rs_reg;
    assign rsp.running_id     = o_rid_reg;
    assign rsp.switch_request = o_sw_reg;
    assign rsp.fired_events   = o_fe_reg;
    assign rsp.new_id         = o_nid_reg;

    // sequence one command through the memories
    always_comb
    begin
        state_next = state_reg;
        alive_next = alive_reg;
        blk_next   = blk_reg;
        slp_next   = slp_reg;
        run_next   = run_reg;
        live_next  = live_reg;
        idc_next   = idc_reg;
        tick_next  = tick_reg;
        evc_next   = evc_reg;
        kind_next  = kind_reg;
        prio_next  = prio_reg;
        tid_next   = tid_reg;
        sl_next    = sl_reg;
        per_next   = per_reg;
        tslot_next = tslot_reg;
        bval_next  = bval_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        best_next  = best_reg;
        pick_next  = pick_reg;
        slot_next  = slot_reg;
        anc_next   = anc_reg;
        p1s_next   = p1s_reg;
        p1v_next   = p1v_reg;
        p2s_next   = p2s_reg;
        p2v_next   = p2v_reg;
        st_next    = st_reg;
        sw_next    = sw_reg;
        fired_next = fired_reg;
        nid_next   = nid_reg;
        ov_next    = ov_reg && !rsp.ready;
        o_st_next  = o_st_reg;
        o_rs_next  = o_rs_reg;
        o_rid_next = o_rid_reg;
        o_sw_next  = o_sw_reg;
        o_fe_next  = o_fe_reg;
        o_nid_next = o_nid_reg;
        thr_raddr  = run_reg;
        thr_wr     = '0;
        ev_raddr   = cnt_reg[EV_BITS-1:0];
        ev_wr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    prio_next  = cmd.priority_req;
                    tid_next   = cmd.target_id;
                    sl_next    = cmd.sleep_ticks;
                    per_next   = cmd.event_period;
                    tslot_next = cmd.target_slot;
                    bval_next  = cmd.block_value;
                    st_next    = ST_OK;
                    sw_next    = 1'b0;
                    fired_next = '0;
                    nid_next   = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FIN_RD;
                unique case (kind_reg)
                    KIND_TICK:
                    begin
                        tick_next  = tick_reg + TIME_BITS'(1);
                        sw_next    = 1'b1;
                        cnt_next   = '0;
                        state_next = S_EV_TEST;
                    end
                    KIND_SCHED:
                    begin
                        if (live_reg != 4'd0)
                        begin
                            state_next = S_WALK_RD0;
                        end
                    end
                    KIND_ADD:
                    begin
                        if (live_reg >= 4'(THREAD_SLOTS))
                        begin
                            st_next = ST_FULL;
                        end
                        else if (!free_found)
                        begin
                            st_next = ST_NO_FREE;
                        end
                        else
                        begin
                            slot_next = free_idx;
                            nid_next  = {idc_reg, 13'd0, free_idx};
                            idc_next  = idc_reg + 16'd1;
                            slp_next[free_idx] = 1'b0;
                            blk_next[free_idx] = 1'b0;
                            if (live_reg == 4'd0)
                            begin
                                // first thread forms a ring of its own
                                thr_wr.en         = 1'b1;
                                thr_wr.addr       = free_idx;
                                thr_wr.data.prio  = prio_reg;
                                thr_wr.data.wake  = '0;
                                thr_wr.data.ident = {idc_reg, 13'd0, free_idx};
                                thr_wr.data.nxt   = free_idx;
                                thr_wr.data.prv   = free_idx;
                                alive_next[free_idx] = 1'b1;
                                live_next = live_reg + 4'd1;
                            end
                            else
                            begin
                                anc_next   = first_alive;
                                state_next = S_ADD_RD;
                            end
                        end
                    end
                    KIND_KILL_ID:
                    begin
                        if (live_reg == 4'd1)
                        begin
                            st_next = ST_LAST;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            state_next = S_FIND_TEST;
                        end
                    end
                    KIND_KILL_SELF:
                    begin
                        if (live_reg == 4'd1)
                        begin
                            st_next = ST_LAST;
                        end
                        else if (!alive_reg[run_reg])
                        begin
                            st_next = ST_NO_THR;
                        end
                        else
                        begin
                            slot_next  = run_reg;
                            sw_next    = 1'b1;
                            state_next = S_UNL_RD;
                        end
                    end
                    KIND_SLEEP:
                    begin
                        slp_next[run_reg] = 1'b1;
                        sw_next    = 1'b1;
                        state_next = S_SLP_RD;
                    end
                    KIND_ADD_EV:
                    begin
                        if (evc_reg >= 4'(EVENT_SLOTS))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            ev_wr.en          = 1'b1;
                            ev_wr.addr        = evc_reg[EV_BITS-1:0];
                            ev_wr.data.period = per_reg;
                            ev_wr.data.due    = TIME_BITS'(evc_reg) + TIME_BITS'(1);
                            evc_next = evc_reg + 4'd1;
                        end
                    end
                    KIND_SET_BLK:
                    begin
                        blk_next[tslot_reg] = bval_reg;
                    end
                    default:
                    begin
                        state_next = S_FIN_RD;
                    end
                endcase
            end
            // link a new thread just before the lowest live slot
            S_ADD_RD:
            begin
                thr_raddr  = anc_reg;
                state_next = S_ADD_GET;
            end
            S_ADD_GET:
            begin
                thr_wr.en         = 1'b1;
                thr_wr.addr       = slot_reg;
                thr_wr.data.prio  = prio_reg;
                thr_wr.data.wake  = '0;
                thr_wr.data.ident = nid_reg;
                thr_wr.data.nxt   = anc_reg;
                thr_wr.data.prv   = thr_q.prv;
                p1s_next = thr_q.prv;
                p1v_next = slot_reg;
                p2s_next = anc_reg;
                p2v_next = slot_reg;
                alive_next[slot_reg] = 1'b1;
                live_next  = live_reg + 4'd1;
                state_next = S_P1_RD;
            end
            // take a slot out of the ring
            S_UNL_RD:
            begin
                thr_raddr  = slot_reg;
                state_next = S_UNL_GET;
            end
            S_UNL_GET:
            begin
                p1s_next = thr_q.prv;
                p1v_next = thr_q.nxt;
                p2s_next = thr_q.nxt;
                p2v_next = thr_q.prv;
                alive_next[slot_reg] = 1'b0;
                live_next  = live_reg - 4'd1;
                state_next = S_P1_RD;
            end
            // patch next link, then prev link
            S_P1_RD:
            begin
                thr_raddr  = p1s_reg;
                state_next = S_P1_WR;
            end
            S_P1_WR:
            begin
                thr_wr.en       = 1'b1;
                thr_wr.addr     = p1s_reg;
                thr_wr.data     = thr_q;
                thr_wr.data.nxt = p1v_reg;
                state_next      = S_P2_RD;
            end
            S_P2_RD:
            begin
                thr_raddr  = p2s_reg;
                state_next = S_P2_WR;
            end
            S_P2_WR:
            begin
                thr_wr.en       = 1'b1;
                thr_wr.addr     = p2s_reg;
                thr_wr.data     = thr_q;
                thr_wr.data.prv = p2v_reg;
                state_next      = S_FIN_RD;
            end
            // store wake time of the running slot
            S_SLP_RD:
            begin
                state_next = S_SLP_WR;
            end
            S_SLP_WR:
            begin
                thr_wr.en        = 1'b1;
                thr_wr.addr      = run_reg;
                thr_wr.data      = thr_q;
                thr_wr.data.wake = sl_reg + tick_reg;
                state_next       = S_FIN_RD;
            end
            // search live slots for the id
            S_FIND_TEST:
            begin
                if (cnt_reg == 4'(THREAD_SLOTS))
                begin
                    st_next    = ST_NO_THR;
                    state_next = S_FIN_RD;
                end
                else
                begin
                    thr_raddr  = cnt_reg[SLOT_BITS-1:0];
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                if (alive_reg[cnt_reg[SLOT_BITS-1:0]] && thr_q.ident == tid_reg)
                begin
                    slot_next  = cnt_reg[SLOT_BITS-1:0];
                    sw_next    = (cnt_reg[SLOT_BITS-1:0] == run_reg);
                    state_next = S_UNL_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_FIND_TEST;
                end
            end
            // fire due events
            S_EV_TEST:
            begin
                if (cnt_reg >= evc_reg)
                begin
                    state_next = (live_reg == 4'd0) ? S_FIN_RD : S_WALK_RD0;
                end
                else
                begin
                    state_next = S_EV_CHK;
                end
            end
            S_EV_CHK:
            begin
                if (ev_q.due == tick_reg)
                begin
                    ev_wr.en          = 1'b1;
                    ev_wr.addr        = cnt_reg[EV_BITS-1:0];
                    ev_wr.data.period = ev_q.period;
                    ev_wr.data.due    = ev_q.period + tick_reg;
                    fired_next[cnt_reg[EV_BITS-1:0]] = 1'b1;
                end
                cnt_next   = cnt_reg + 4'd1;
                state_next = S_EV_TEST;
            end
            // walk the ring after the running slot
            S_WALK_RD0:
            begin
                state_next = S_WALK_GET0;
            end
            S_WALK_GET0:
            begin
                cur_next   = thr_q.nxt;
                cnt_next   = '0;
                best_next  = 9'd256;
                pick_next  = run_reg;
                state_next = S_WALK_TEST;
            end
            S_WALK_TEST:
            begin
                if (cnt_reg == 4'(THREAD_SLOTS) || cur_reg == run_reg)
                begin
                    if (kind_reg == KIND_SCHED)
                    begin
                        run_next = pick_reg;
                    end
                    state_next = S_FIN_RD;
                end
                else
                begin
                    thr_raddr  = cur_reg;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (kind_reg == KIND_SCHED)
                begin
                    if (alive_reg[cur_reg] && !blk_reg[cur_reg] && !slp_reg[cur_reg]
                        && {1'b0, thr_q.prio} < best_reg)
                    begin
                        pick_next = cur_reg;
                        best_next = {1'b0, thr_q.prio};
                    end
                end
                else if (alive_reg[cur_reg] && slp_reg[cur_reg]
                         && thr_q.wake <= tick_reg)
                begin
                    slp_next[cur_reg] = 1'b0;
                end
                cur_next   = thr_q.nxt;
                cnt_next   = cnt_reg + 4'd1;
                state_next = S_WALK_TEST;
            end
            // read running entry and hand out the result
            S_FIN_RD:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    o_st_next  = st_reg;
                    o_rs_next  = run_reg;
                    o_rid_next = alive_reg[run_reg] ? thr_q.ident : '0;
                    o_sw_next  = sw_reg;
                    o_fe_next  = fired_reg;
                    o_nid_next = nid_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state, thread marks, counters and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alive_reg <= '0;
            blk_reg   <= '0;
            slp_reg   <= '0;
            run_reg   <= '0;
            live_reg  <= '0;
            idc_reg   <= '0;
            tick_reg  <= '0;
            evc_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alive_reg <= alive_next;
            blk_reg   <= blk_next;
            slp_reg   <= slp_next;
            run_reg   <= run_next;
            live_reg  <= live_next;
            idc_reg   <= idc_next;
            tick_reg  <= tick_next;
            evc_reg   <= evc_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        prio_reg  <= prio_next;
        tid_reg   <= tid_next;
        sl_reg    <= sl_next;
        per_reg   <= per_next;
        tslot_reg <= tslot_next;
        bval_reg  <= bval_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        best_reg  <= best_next;
        pick_reg  <= pick_next;
        slot_reg  <= slot_next;
        anc_reg   <= anc_next;
        p1s_reg   <= p1s_next;
        p1v_reg   <= p1v_next;
        p2s_reg   <= p2s_next;
        p2v_reg   <= p2v_next;
        st_reg    <= st_next;
        sw_reg    <= sw_next;
        fired_reg <= fired_next;
        nid_reg   <= nid_next;
        o_st_reg  <= o_st_next;
        o_rs_reg  <= o_rs_next;
        o_rid_reg <= o_rid_next;
        o_sw_reg  <= o_sw_next;
        o_fe_reg  <= o_fe_next;
        o_nid_reg <= o_nid_next;
    end

    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(alive_reg) == 32'(live_reg))
        else $error("live count disagrees with alive marks");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish step");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !thr_wr.en && !ev_wr.en)
        else $error("memory write while idle");

endmodule
